// ===== rtl/brfla_pkg.sv =====
// Package: types, codes and constants of the run free-list block allocator.
package brfla_pkg;

  localparam int unsigned BlkW          = 10;
  localparam int unsigned SizeW         = 11;
  localparam int unsigned NumBlocksDflt = 1024;
  localparam int unsigned BlkLimit      = 1 << BlkW;
  localparam logic [BlkW-1:0]  CntMax   = {BlkW{1'b1}};
  localparam logic [SizeW-1:0] VolReset = 11'd1024;
  localparam logic [SizeW-1:0] VolMin   = 11'd2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_ALLOC
  } state_e;

  typedef struct packed {
    opcode_e         opcode;
    logic [BlkW-1:0] block_in;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [BlkW-1:0] block_out;
    logic [BlkW-1:0] free_left;
  } out_item_t;

  typedef struct packed {
    logic [BlkW-1:0] length;
    logic [BlkW-1:0] link;
  } run_rec_t;

endpackage

// ===== rtl/brfla_run_mem.sv =====
// Run record memory: one write port, one read port, registered read data.
module brfla_run_mem
  import brfla_pkg::*;
#(
  parameter int unsigned DEPTH  = NumBlocksDflt,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  run_rec_t          wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output run_rec_t          rdata_o
);

  run_rec_t mem [DEPTH];
  run_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/block_run_free_list_allocator_top.sv =====
// Top level: run free-list block allocator with its head and count registers.
//
// Input channel (in_valid_i / in_stall_o) takes one command item: allocate,
// free a block, or format the volume. Each item gives exactly one result item
// on the output channel (out_valid_o / out_stall_i), held in an output
// register until the receiver takes it.
// Free, format, an unused opcode, and an allocate that finds no free block
// finish in the accept cycle: the result is valid in the next cycle and the
// next item can be accepted in the following cycle. A successful allocate
// reads the head run record from the run memory (registered read data), then
// in the S_ALLOC state writes the updated record back and registers the result.
// A new item is accepted only while no allocate is in flight and the output
// register is empty or being taken; a stalled receiver therefore holds off
// the input channel after one result.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the volume
// size and is always ready; write it only while the block is idle.
// Reset empties the free list and the count, sets the volume size to 1024,
// and clears the output valid flag. Run records are undefined until a format
// or free writes them; no clearing pass is run.
module block_run_free_list_allocator_top
  import brfla_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  localparam int unsigned MemDepth = (NUM_BLOCKS < BlkLimit) ? NUM_BLOCKS : BlkLimit;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam logic [SizeW-1:0] SizeMax = SizeW'(MemDepth);

  state_e          state_q, state_d;
  logic [BlkW-1:0] head_q, head_d;
  logic [BlkW-1:0] free_q, free_d;
  logic [SizeW-1:0] vol_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;

  logic            in_acc;
  logic [SizeW-1:0] size;
  logic            mem_we;
  logic [AddrW-1:0] mem_waddr;
  run_rec_t        mem_wdata;
  run_rec_t        mem_rdata;
  logic            alloc_ok;
  logic [SizeW-1:0] head_nxt;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    size = vol_q;
    if (size < VolMin) size = VolMin;
    if (size > SizeMax) size = SizeMax;
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign alloc_ok   = (free_q != '0) && (head_q != '0)
                      && (SizeW'(head_q) < SizeMax);
  assign head_nxt   = SizeW'(head_q) + SizeW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_item_i.opcode == OP_ALLOC && alloc_ok) state_d = S_ALLOC;
      end
      S_ALLOC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q[AddrW-1:0];
    mem_wdata   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d          = 1'b1;
          out_item_d.status    = ST_OK;
          out_item_d.block_out = '0;
          out_item_d.free_left = free_q;
          case (in_item_i.opcode)
            OP_FORMAT: begin
              head_d               = BlkW'(1);
              free_d               = BlkW'(size - SizeW'(1));
              mem_we               = 1'b1;
              mem_waddr            = AddrW'(1);
              mem_wdata.length     = BlkW'(size - SizeW'(1));
              mem_wdata.link       = '0;
              out_item_d.free_left = BlkW'(size - SizeW'(1));
            end
            OP_ALLOC: begin
              if (alloc_ok) begin
                out_valid_d = 1'b0;
              end else begin
                out_item_d.status = ST_FULL;
              end
            end
            OP_FREE: begin
              if (in_item_i.block_in == '0 || SizeW'(in_item_i.block_in) >= size) begin
                out_item_d.status = ST_INVALID;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = in_item_i.block_in[AddrW-1:0];
                mem_wdata.length = BlkW'(1);
                mem_wdata.link   = head_q;
                head_d           = in_item_i.block_in;
                if (free_q < CntMax) begin
                  free_d               = free_q + BlkW'(1);
                  out_item_d.free_left = free_q + BlkW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        if (mem_rdata.length > BlkW'(1) && head_nxt < size) begin
          mem_we           = 1'b1;
          mem_waddr        = AddrW'(head_nxt);
          mem_wdata.length = mem_rdata.length - BlkW'(1);
          mem_wdata.link   = mem_rdata.link;
          head_d           = BlkW'(head_nxt);
        end else begin
          head_d = mem_rdata.link;
        end
        free_d               = free_q - BlkW'(1);
        out_valid_d          = 1'b1;
        out_item_d.status    = ST_OK;
        out_item_d.block_out = head_q;
        out_item_d.free_left = free_q - BlkW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      free_q      <= '0;
      vol_q       <= VolReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  brfla_run_mem #(
    .DEPTH  (MemDepth),
    .ADDR_W (AddrW)
  ) u_run_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the run free-list block allocator: directed command table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brfla_pkg::*;

  localparam int unsigned NumBlk    = NumBlocksDflt;
  localparam int unsigned BlkSpan   = (NumBlk < BlkLimit) ? NumBlk : BlkLimit;
  localparam logic [SizeW-1:0] SpanSize = SizeW'(BlkSpan);
  localparam opcode_e     OpUnused  = opcode_e'(2'd3);
  localparam int unsigned MaxCycles = 500000;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned Phases    = 16;
  localparam int unsigned PhaseLen  = 94;

  typedef struct packed {
    bit               is_cfg;
    logic [SizeW-1:0] size;
    in_item_t         cmd;
    bit               checked;
    out_item_t        want;
  } plan_row_t;

  // volume size starts at its reset value
  localparam plan_row_t Plan [28] = '{
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_FULL,    10'd0,    10'd0}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd0},    1'b1, '{ST_INVALID, 10'd0,    10'd0}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1023}, 1'b1, '{ST_OK,      10'd0,    10'd1}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'h155},  1'b1, '{ST_OK,      10'd1023, 10'd0}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_FULL,    10'd0,    10'd0}},
    '{1'b0, 11'd0,    '{OpUnused,  10'd1023}, 1'b1, '{ST_OK,      10'd0,    10'd0}},
    '{1'b0, 11'd0,    '{OP_FORMAT, 10'd1023}, 1'b1, '{ST_OK,      10'd0,    10'd1023}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_OK,      10'd1,    10'd1022}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_OK,      10'd2,    10'd1021}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1},    1'b0, '0},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1},    1'b0, '0},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1},    1'b1, '{ST_OK,      10'd0,    10'd1023}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b0, '0},
    '{1'b1, 11'd2,    '0,                     1'b0, '0},
    '{1'b0, 11'd0,    '{OP_FORMAT, 10'd0},    1'b1, '{ST_OK,      10'd0,    10'd1}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd2},    1'b1, '{ST_INVALID, 10'd0,    10'd1}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_OK,      10'd1,    10'd0}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_FULL,    10'd0,    10'd0}},
    '{1'b1, 11'd0,    '0,                     1'b0, '0},
    '{1'b0, 11'd0,    '{OP_FORMAT, 10'd0},    1'b1, '{ST_OK,      10'd0,    10'd1}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1},    1'b0, '0},
    '{1'b1, 11'h7FF,  '0,                     1'b0, '0},
    '{1'b0, 11'd0,    '{OP_FORMAT, 10'h2AA},  1'b1, '{ST_OK,      10'd0,    10'd1023}},
    '{1'b0, 11'd0,    '{OP_FREE,   10'd1023}, 1'b1, '{ST_OK,      10'd0,    10'd1023}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_OK,      10'd1023, 10'd1022}},
    '{1'b0, 11'd0,    '{OP_ALLOC,  10'd0},    1'b1, '{ST_OK,      10'd1,    10'd1021}},
    '{1'b1, 11'd1,    '0,                     1'b0, '0},
    '{1'b0, 11'd0,    '{OpUnused,  10'd0},    1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SizeW-1:0] cfg_data;

  logic [SizeW-1:0] vol_size;
  logic [BlkW-1:0]  head_blk;
  logic [BlkW-1:0]  free_cnt;
  logic [BlkW-1:0]  run_len  [NumBlk];
  logic [BlkW-1:0]  run_next [NumBlk];

  out_item_t       pending_q[$];
  out_item_t       due;
  logic [BlkW-1:0] held[$];
  int unsigned     errors    = 0;
  int unsigned     n_cmds    = 0;
  int unsigned     n_sizes   = 0;
  int unsigned     n_granted = 0;
  int unsigned     n_full    = 0;
  int unsigned     n_invalid = 0;
  int unsigned     cycles    = 0;
  bit              calm      = 1'b0;
  bit              hold_req  = 1'b0;

  block_run_free_list_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [SizeW-1:0] usable_blocks();
    logic [SizeW-1:0] s;
    s = vol_size;
    if (s < VolMin) s = VolMin;
    if (s > SpanSize) s = SpanSize;
    return s;
  endfunction

  function automatic out_item_t allocator_step(input in_item_t cmd);
    out_item_t        res;
    logic [SizeW-1:0] size;
    logic [BlkW-1:0]  h;
    logic [SizeW-1:0] h_next;
    logic [BlkW-1:0]  len;
    logic [BlkW-1:0]  nxt;
    size = usable_blocks();
    res  = '{ST_OK, '0, '0};
    case (cmd.opcode)
      OP_FORMAT: begin
        head_blk    = BlkW'(1);
        free_cnt    = BlkW'(size - SizeW'(1));
        run_len[1]  = BlkW'(size - SizeW'(1));
        run_next[1] = '0;
      end
      OP_ALLOC: begin
        h = head_blk;
        if (free_cnt == '0 || h == '0 || SizeW'(h) >= SpanSize) begin
          res.status = ST_FULL;
        end else begin
          len           = run_len[h];
          nxt           = run_next[h];
          h_next        = SizeW'(h) + SizeW'(1);
          res.block_out = h;
          if (len > BlkW'(1) && h_next < size && h_next < SpanSize) begin
            run_len[h_next[BlkW-1:0]]  = len - BlkW'(1);
            run_next[h_next[BlkW-1:0]] = nxt;
            head_blk                   = h_next[BlkW-1:0];
          end else begin
            head_blk = nxt;
          end
          free_cnt = free_cnt - BlkW'(1);
        end
      end
      OP_FREE: begin
        if (cmd.block_in == '0 || SizeW'(cmd.block_in) >= size) begin
          res.status = ST_INVALID;
        end else begin
          run_len[cmd.block_in]  = BlkW'(1);
          run_next[cmd.block_in] = head_blk;
          head_blk               = cmd.block_in;
          if (free_cnt < CntMax) free_cnt = free_cnt + BlkW'(1);
        end
      end
      default: ;
    endcase
    res.free_left = free_cnt;
    return res;
  endfunction

  task automatic issue_cmd(input in_item_t cmd, input bit checked, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk_i); while (in_stall);
    res = allocator_step(cmd);
    pending_q.push_back(checked ? want : res);
    n_cmds++;
    if (cmd.opcode == OP_FORMAT) begin
      held.delete();
    end else if (cmd.opcode == OP_ALLOC && res.status == ST_OK) begin
      held.push_back(res.block_out);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_volume(input logic [SizeW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    vol_size = v;
    n_sizes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end
      n = calm ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $error("unexpected result item: %p", out_item);
      end else begin
        due = pending_q.pop_front();
        if (out_item.status !== due.status) begin
          errors++;
          $error("status: expected %0d, got %0d", due.status, out_item.status);
        end
        if (out_item.block_out !== due.block_out) begin
          errors++;
          $error("block_out: expected %0d, got %0d", due.block_out, out_item.block_out);
        end
        if (out_item.free_left !== due.free_left) begin
          errors++;
          $error("free_left: expected %0d, got %0d", due.free_left, out_item.free_left);
        end
        case (due.status)
          ST_FULL:    n_full++;
          ST_INVALID: n_invalid++;
          default:    if (due.block_out != '0) n_granted++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t         cmd;
    logic [SizeW-1:0] v;
    int unsigned      r;
    int unsigned      idx;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    vol_size  = VolReset;
    head_blk  = '0;
    free_cnt  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].is_cfg) set_volume(Plan[i].size);
      else issue_cmd(Plan[i].cmd, Plan[i].checked, Plan[i].want);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0:       v = VolMin;
        1:       v = VolReset;
        2:       v = '0;
        3:       v = 11'd1025;
        4:       v = 11'h7FF;
        5:       v = 11'd1;
        default: v = ($urandom_range(0, 2) == 0) ? 11'($urandom_range(2, 1024))
                                                 : 11'($urandom_range(2, 48));
      endcase
      set_volume(v);
      calm = (ph % 5 == 2);
      if (ph == 3) hold_req = 1'b1;
      cmd = '{OP_FORMAT, 10'($urandom)};
      issue_cmd(cmd, 1'b0, '0);
      repeat (PhaseLen) begin
        r            = $urandom_range(0, 99);
        cmd.block_in = 10'($urandom);
        if (r < 3) begin
          cmd.opcode = OP_FORMAT;
        end else if (r < 7) begin
          cmd.opcode = OpUnused;
        end else if (r < 12) begin
          cmd.opcode = OP_FREE;
        end else if (r < 50 && held.size() != 0) begin
          idx          = $urandom_range(0, held.size() - 1);
          cmd.opcode   = OP_FREE;
          cmd.block_in = held[idx];
          held.delete(idx);
        end else begin
          cmd.opcode = OP_ALLOC;
        end
        issue_cmd(cmd, 1'b0, '0);
      end
    end
    calm = 1'b0;
    drain();

    $display("%0d commands over %0d volume-size writes", n_cmds, n_sizes);
    $display("%0d blocks granted, %0d full, %0d invalid frees, %0d mismatches",
             n_granted, n_full, n_invalid, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brfla_pkg.sv
rtl/brfla_run_mem.sv
rtl/block_run_free_list_allocator_top.sv
tb/sv/tb_top.sv
